[design/fqdf_pkg.sv]
// fqdf_pkg: shared types and codes for the FASTQ record deframer.
// Holds the item and result structs, the queue entry type and the byte, kind,
// field and error codes. It depends on nothing else.
`timescale 1ns / 1ps

package fqdf_pkg;

	// Fixed field widths
	localparam int CFG_W    = 16;
	localparam int FLEN_W   = 16;
	localparam int REC_W    = 32;
	localparam int Q_DEPTH  = 4;

	// Characters that the parser looks for
	localparam logic [7:0] CH_AT   = 8'h40;
	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_LF   = 8'h0A;

	// Result kinds
	localparam logic [2:0] KIND_ID     = 3'd0;
	localparam logic [2:0] KIND_SEQ    = 3'd1;
	localparam logic [2:0] KIND_QUAL   = 3'd2;
	localparam logic [2:0] KIND_FEND   = 3'd3;
	localparam logic [2:0] KIND_STATUS = 3'd4;

	// Field kinds carried by a field end
	localparam logic [1:0] FK_ID   = 2'd0;
	localparam logic [1:0] FK_SEQ  = 2'd1;
	localparam logic [1:0] FK_QUAL = 2'd2;

	// Line phase within a record
	localparam logic [1:0] PH_ID   = 2'd0;
	localparam logic [1:0] PH_SEQ  = 2'd1;
	localparam logic [1:0] PH_SEP  = 2'd2;
	localparam logic [1:0] PH_QUAL = 2'd3;

	// Error codes
	localparam logic [2:0] ERR_NONE   = 3'd0;
	localparam logic [2:0] ERR_AT     = 3'd1;
	localparam logic [2:0] ERR_PLUS   = 3'd2;
	localparam logic [2:0] ERR_LEN    = 3'd3;
	localparam logic [2:0] ERR_INCOMP = 3'd4;
	localparam logic [2:0] ERR_LONG   = 3'd5;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_stream;
	} in_item_t;

	typedef struct packed {
		logic [2:0]        kind;
		logic [7:0]        out_byte;
		logic [1:0]        field_kind;
		logic [FLEN_W-1:0] field_length;
		logic [REC_W-1:0]  record_count;
		logic [2:0]        error_code;
		logic              last;
	} out_item_t;

	// One queue entry: the results of one input item, one or two of them
	typedef struct packed {
		logic      two;
		out_item_t r0;
		out_item_t r1;
	} qent_t;

endpackage

[design/fastq_record_deframer_top.sv]
// fastq_record_deframer_top: FASTQ byte stream to tagged field bytes, field ends
// and status. Instantiates fqdf_front, fqdf_queue and fqdf_back; uses fqdf_pkg.
//
//   channel  | direction | handshake                  | payload
//   item     | in        | item_valid / item_ready     | in_item_t: data_byte, end_of_stream
//   result   | out       | result_valid / result_ready | out_item_t: kind ... last
//   cfg      | in        | cfg_we (no wait)            | cfg_wdata: max_line_length
//
// One byte is accepted per cycle while the four-entry result queue has room.
// Results leave the output register one at a time, so an item that makes two results
// yields them in turn; accepted items pass through the queue, then the output register.
// Reset clears all parser state, the queue and the output; max_line_length resets
// to 65535. A stalled output fills the queue and then holds item_ready low.
`timescale 1ns / 1ps

module fastq_record_deframer_top #(
	parameter int LENGTH_BITS = 16,
	parameter int COUNT_BITS  = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       item_valid,
	output logic                       item_ready,
	input  fqdf_pkg::in_item_t         item,
	output logic                       result_valid,
	input  logic                       result_ready,
	output fqdf_pkg::out_item_t        result,
	input  logic                       cfg_we,
	input  logic [fqdf_pkg::CFG_W-1:0] cfg_wdata
);
	import fqdf_pkg::*;

	logic  q_full;
	logic  push;
	qent_t entry;
	logic  head_valid;
	qent_t head;
	logic  pop;

	// Parser and classifier
	fqdf_front #(
		.LENGTH_BITS (LENGTH_BITS),
		.COUNT_BITS  (COUNT_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.q_full     (q_full),
		.push       (push),
		.entry      (entry)
	);

	// Result queue
	fqdf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.wr_entry   (entry),
		.full       (q_full),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	// Output sequencer
	fqdf_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

[design/fqdf_front.sv]
// fqdf_front: accepts input bytes, tracks line phase, lengths, record count and
// the sticky error, and turns each item into a queue entry of one or two results.
// Depends on fqdf_pkg.
`timescale 1ns / 1ps

module fqdf_front #(
	parameter int LENGTH_BITS = 16,
	parameter int COUNT_BITS  = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      item_valid,
	output logic                      item_ready,
	input  fqdf_pkg::in_item_t        item,
	input  logic                      cfg_we,
	input  logic [fqdf_pkg::CFG_W-1:0] cfg_wdata,
	input  logic                      q_full,
	output logic                      push,
	output fqdf_pkg::qent_t           entry
);
	import fqdf_pkg::*;

	localparam int CMP_W = (LENGTH_BITS > CFG_W) ? LENGTH_BITS : CFG_W;

	function automatic out_item_t mk_status(input logic [2:0] code,
			input logic [REC_W-1:0] rec);
		out_item_t r;
		r = '0;
		r.kind = KIND_STATUS;
		r.record_count = rec;
		r.error_code = code;
		return r;
	endfunction

	function automatic out_item_t mk_content(input logic [2:0] k, input logic [7:0] b,
			input logic [REC_W-1:0] rec);
		out_item_t r;
		r = '0;
		r.kind = k;
		r.out_byte = b;
		r.record_count = rec;
		return r;
	endfunction

	function automatic out_item_t mk_fend(input logic [1:0] fk,
			input logic [FLEN_W-1:0] flen, input logic [REC_W-1:0] rec);
		out_item_t r;
		r = '0;
		r.kind = KIND_FEND;
		r.field_kind = fk;
		r.field_length = flen;
		r.record_count = rec;
		return r;
	endfunction

	// State registers
	logic [CFG_W-1:0]       max_len_q;
	logic [1:0]             phase_q;
	logic                   start_q;
	logic                   cr_q;
	logic [LENGTH_BITS-1:0] len_q;
	logic [LENGTH_BITS-1:0] seq_q;
	logic [COUNT_BITS-1:0]  rec_q;
	logic [2:0]             err_q;

	// Next state
	logic [1:0]             n_phase;
	logic                   n_start;
	logic                   n_cr;
	logic [LENGTH_BITS-1:0] n_len;
	logic [LENGTH_BITS-1:0] n_seq;
	logic [COUNT_BITS-1:0]  n_rec;
	logic [2:0]             n_err;

	logic                   take;
	logic [CMP_W-1:0]       len_max_c;
	logic [CMP_W-1:0]       lim;
	logic                   hit_a;
	logic                   hit_b;
	logic [LENGTH_BITS-1:0] len_b;
	logic [LENGTH_BITS-1:0] len_m1;
	logic [2:0]             ckind;

	// Line end evaluated on the current state
	logic [2:0]             el_err;
	logic [1:0]             el_fk;
	logic [FLEN_W-1:0]      el_flen;
	logic [COUNT_BITS-1:0]  el_rec;

	logic                   err_a;
	logic [2:0]             code_b;
	out_item_t              item_b;
	out_item_t              r0;
	out_item_t              r1;
	logic                   two;

	assign item_ready = !q_full;
	assign take = item_valid && item_ready;

	// Effective line limit, clamped to what the length counter can hold
	assign len_max_c = CMP_W'({LENGTH_BITS{1'b1}});
	assign lim = (CMP_W'(max_len_q) < len_max_c) ? CMP_W'(max_len_q) : len_max_c;
	assign hit_a = CMP_W'(len_q) >= lim;
	// Length seen by the new byte after a released carriage return
	assign len_b = cr_q ? (len_q + LENGTH_BITS'(1)) : len_q;
	assign hit_b = CMP_W'(len_b) >= lim;
	assign len_m1 = len_q - LENGTH_BITS'(1);

	// Content kind follows the line phase
	always_comb begin
		unique case (phase_q)
			PH_ID:   ckind = KIND_ID;
			PH_SEQ:  ckind = KIND_SEQ;
			default: ckind = KIND_QUAL;
		endcase
	end

	// Line end: mark checks, length check, field end contents
	always_comb begin
		el_err = ERR_NONE;
		if (start_q && phase_q == PH_ID) begin
			el_err = ERR_AT;
		end else if (start_q && phase_q == PH_SEP) begin
			el_err = ERR_PLUS;
		end else if (phase_q == PH_QUAL && len_q != seq_q) begin
			el_err = ERR_LEN;
		end
		el_fk = (phase_q == PH_ID) ? FK_ID : ((phase_q == PH_SEQ) ? FK_SEQ : FK_QUAL);
		el_flen = (phase_q == PH_ID) ? FLEN_W'(len_m1) : FLEN_W'(len_q);
		el_rec = (phase_q == PH_QUAL && el_err == ERR_NONE) ? (rec_q + COUNT_BITS'(1))
			: rec_q;
	end

	// Check on the new byte after any released carriage return
	always_comb begin
		code_b = ERR_NONE;
		if (start_q && phase_q == PH_ID && item.data_byte != CH_AT) begin
			code_b = ERR_AT;
		end else if (start_q && phase_q == PH_SEP && item.data_byte != CH_PLUS) begin
			code_b = ERR_PLUS;
		end else if (item.data_byte != CH_CR && hit_b) begin
			code_b = ERR_LONG;
		end
	end

	// Step evaluation: next state and the results of this item
	always_comb begin
		n_phase = phase_q;
		n_start = start_q;
		n_cr    = cr_q;
		n_len   = len_q;
		n_seq   = seq_q;
		n_rec   = rec_q;
		n_err   = err_q;
		r0      = '0;
		r1      = '0;
		two     = 1'b0;
		push    = 1'b0;
		err_a   = 1'b0;
		item_b  = '0;
		if (item.end_of_stream) begin
			if (err_q == ERR_NONE && (!start_q || cr_q)) begin
				// close the open line as if by a line feed
				n_cr = 1'b0;
				push = 1'b1;
				if (el_err != ERR_NONE) begin
					n_err = el_err;
					r0 = mk_status(el_err, REC_W'(rec_q));
				end else begin
					n_phase = phase_q + 2'd1;
					n_len   = '0;
					n_start = 1'b1;
					n_rec   = el_rec;
					if (phase_q == PH_SEQ) begin
						n_seq = len_q;
					end
					if (phase_q == PH_SEP) begin
						n_err = ERR_INCOMP;
						r0 = mk_status(ERR_INCOMP, REC_W'(rec_q));
					end else begin
						r0 = mk_fend(el_fk, el_flen, REC_W'(el_rec));
						two = 1'b1;
						if (phase_q != PH_QUAL) begin
							n_err = ERR_INCOMP;
							r1 = mk_status(ERR_INCOMP, REC_W'(el_rec));
						end else begin
							r1 = mk_status(ERR_NONE, REC_W'(el_rec));
						end
					end
				end
			end else begin
				push = 1'b1;
				if (err_q == ERR_NONE && phase_q != PH_ID) begin
					n_err = ERR_INCOMP;
					r0 = mk_status(ERR_INCOMP, REC_W'(rec_q));
				end else begin
					r0 = mk_status(err_q, REC_W'(rec_q));
				end
			end
		end else if (err_q == ERR_NONE) begin
			if (item.data_byte == CH_LF) begin
				n_cr = 1'b0;
				if (el_err != ERR_NONE) begin
					n_err = el_err;
					r0 = mk_status(el_err, REC_W'(rec_q));
					push = 1'b1;
				end else begin
					n_phase = phase_q + 2'd1;
					n_len   = '0;
					n_start = 1'b1;
					n_rec   = el_rec;
					if (phase_q == PH_SEQ) begin
						n_seq = len_q;
					end
					if (phase_q != PH_SEP) begin
						r0 = mk_fend(el_fk, el_flen, REC_W'(el_rec));
						push = 1'b1;
					end
				end
			end else begin
				// release a held carriage return as content
				if (cr_q) begin
					n_cr = 1'b0;
					if (hit_a) begin
						err_a = 1'b1;
						n_err = ERR_LONG;
						r0 = mk_status(ERR_LONG, REC_W'(rec_q));
						push = 1'b1;
					end else if (phase_q != PH_SEP) begin
						r0 = mk_content(ckind, CH_CR, REC_W'(rec_q));
						push = 1'b1;
					end
				end
				if (!err_a) begin
					n_len = len_b;
					if (code_b != ERR_NONE) begin
						n_err = code_b;
						item_b = mk_status(code_b, REC_W'(rec_q));
					end else begin
						n_start = 1'b0;
						if (item.data_byte == CH_CR) begin
							n_cr = 1'b1;
						end else begin
							n_len = len_b + LENGTH_BITS'(1);
							if (!(start_q && phase_q == PH_ID) && phase_q != PH_SEP) begin
								item_b = mk_content(ckind, item.data_byte, REC_W'(rec_q));
							end
						end
					end
					// place into the first free slot
					if (item_b.kind == KIND_STATUS || item_b.kind != KIND_ID
						|| (!(start_q && phase_q == PH_ID) && phase_q != PH_SEP
						&& code_b == ERR_NONE && item.data_byte != CH_CR)) begin
						if (code_b != ERR_NONE || (item.data_byte != CH_CR
							&& !(start_q && phase_q == PH_ID) && phase_q != PH_SEP)) begin
							if (push) begin
								r1 = item_b;
								two = 1'b1;
							end else begin
								r0 = item_b;
								push = 1'b1;
							end
						end
					end
				end
			end
		end
		if (!take) begin
			push = 1'b0;
		end
	end

	assign entry.two = two;
	assign entry.r0  = r0;
	assign entry.r1  = r1;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= '1;
		end else if (cfg_we) begin
			max_len_q <= cfg_wdata;
		end
	end

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_ID;
			start_q <= 1'b1;
			cr_q    <= 1'b0;
			len_q   <= '0;
			seq_q   <= '0;
			rec_q   <= '0;
			err_q   <= ERR_NONE;
		end else if (take) begin
			phase_q <= n_phase;
			start_q <= n_start;
			cr_q    <= n_cr;
			len_q   <= n_len;
			seq_q   <= n_seq;
			rec_q   <= n_rec;
			err_q   <= n_err;
		end
	end

endmodule

[design/fqdf_queue.sv]
// fqdf_queue: short register queue of result entries between front and back.
// One push and one pop per cycle. Depends on fqdf_pkg.
`timescale 1ns / 1ps

module fqdf_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  fqdf_pkg::qent_t wr_entry,
	output logic            full,
	output logic            head_valid,
	output fqdf_pkg::qent_t head,
	input  logic            pop
);
	import fqdf_pkg::*;

	localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int CNT_W = $clog2(Q_DEPTH + 1);

	qent_t            mem_q [Q_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full       = (cnt_q == CNT_W'(Q_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	// Entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

[design/fqdf_back.sv]
// fqdf_back: drains queue entries into the output register one result per cycle
// unless stalled, marking the final result of each entry. Depends on fqdf_pkg.
`timescale 1ns / 1ps

module fqdf_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 head_valid,
	input  fqdf_pkg::qent_t      head,
	output logic                 pop,
	output logic                 result_valid,
	input  logic                 result_ready,
	output fqdf_pkg::out_item_t  result
);
	import fqdf_pkg::*;

	logic      sel_q;
	logic      valid_q;
	out_item_t out_q;
	logic      load;
	logic      is_last;
	out_item_t cur;

	// Output register takes a new result when empty or being drained
	assign load    = !valid_q || result_ready;
	assign is_last = !head.two || sel_q;
	always_comb begin
		cur = sel_q ? head.r1 : head.r0;
		cur.last = is_last;
	end
	assign pop = load && head_valid && is_last;

	assign result_valid = valid_q;
	assign result       = out_q;

	// Result payload
	always_ff @(posedge clk) begin
		if (load && head_valid) begin
			out_q <= cur;
		end
	end

	// Valid flag and slot select
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sel_q   <= 1'b0;
		end else if (load) begin
			valid_q <= head_valid;
			if (head_valid) begin
				sel_q <= !is_last;
			end
		end
	end

endmodule
